/* src/piecewise_linear_cdf_lookup_defines.svh */
// Assertion macros shared by the lookup block.
`ifndef PIECEWISE_LINEAR_CDF_LOOKUP_DEFINES_SVH
`define PIECEWISE_LINEAR_CDF_LOOKUP_DEFINES_SVH
`ifndef ASSERT_OFF
`define PLCDF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PLCDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PLCDF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define PLCDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/plcdf_pkg.sv */
`default_nettype none
package plcdf_pkg;
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Head of the queue between the front and the back.
    typedef struct packed {
        logic valid;
        logic is_query;
    } plcdf_head_t;
endpackage
`default_nettype wire

/* src/piecewise_linear_cdf_lookup.sv */
// Channel   Direction  Handshake               Payload
// input     in         push / full             cmd, edge_index, sample_value
// result    out        empty / pop             fraction
// config    in         edge_count_we           edge_count_wdata
//
// An edge write is done by the back end straight from its idle state; a query
// there is paced by the probe reads of the edge memory's one read port and by
// the one-bit-per-cycle divider.
// A two-beat queue lets the front take beats while the back is busy.
// Reset clears control only; edge memory contents are undefined until written.
`default_nettype none
`include "piecewise_linear_cdf_lookup_defines.svh"
module piecewise_linear_cdf_lookup import plcdf_pkg::*; #(
    parameter int MAX_EDGES = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         cmd,
    input  wire logic [$clog2(MAX_EDGES)-1:0] edge_index,
    input  wire logic signed [31:0]           sample_value,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [FRAC_BITS:0]                fraction,
    input  wire logic                         edge_count_we,
    input  wire logic [$clog2(MAX_EDGES):0]   edge_count_wdata
);
    localparam int CNT_W = $clog2(MAX_EDGES) + 1;
    localparam logic [FRAC_BITS:0] ONE_FRAC = (FRAC_BITS+1)'(1) << FRAC_BITS;

    plcdf_head_t                   head;
    logic [$clog2(MAX_EDGES)-1:0]  head_index;
    logic signed [31:0]            head_value;
    logic                          head_pop;
    logic                          res_valid, res_ready;
    logic [FRAC_BITS:0]            res_fraction;
    logic [CNT_W-1:0]              edge_count_reg;
    logic [CNT_W-1:0]              n_active;
    logic                          out_valid_reg, out_valid_next;
    logic [FRAC_BITS:0]            out_frac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg <= CNT_W'(2);
        end
        else if (edge_count_we)
        begin
            edge_count_reg <= edge_count_wdata;
        end
    end

    always_comb
    begin
        priority if (edge_count_reg < CNT_W'(2))
        begin
            n_active = CNT_W'(2);
        end
        else if (edge_count_reg > CNT_W'(MAX_EDGES))
        begin
            n_active = CNT_W'(MAX_EDGES);
        end
        else
        begin
            n_active = edge_count_reg;
        end
    end

    plcdf_front #(.MAX_EDGES(MAX_EDGES)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .edge_index   (edge_index),
        .sample_value (sample_value),
        .head         (head),
        .head_index   (head_index),
        .head_value   (head_value),
        .head_pop     (head_pop)
    );

    plcdf_back #(.MAX_EDGES(MAX_EDGES), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .n_active     (n_active),
        .head         (head),
        .head_index   (head_index),
        .head_value   (head_value),
        .head_pop     (head_pop),
        .res_valid    (res_valid),
        .res_fraction (res_fraction),
        .res_ready    (res_ready)
    );

    // Output register: the back hands over a result whenever this slot frees up.
    assign res_ready = !out_valid_reg || pop;
    assign empty     = !out_valid_reg;
    assign fraction  = out_frac_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_frac_reg <= res_fraction;
        end
    end

    `PLCDF_ASSERT_IMPLIES(a_frac_range, clk, rst_n, !empty, fraction <= ONE_FRAC, "fraction above one")
    `PLCDF_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_fraction), "back result dropped while stalled")
    `PLCDF_ASSERT_NEXT(a_pop_clears, clk, rst_n, pop && !empty && !res_valid, empty, "output slot not freed by pop")
    `PLCDF_ASSERT_IMPLIES(a_write_idle, clk, rst_n, head_pop && !head.is_query, !res_valid, "edge write while a result is in flight")
endmodule
`default_nettype wire

/* src/plcdf_ram.sv */
`default_nettype none
module plcdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* src/plcdf_front.sv */
`default_nettype none
module plcdf_front import plcdf_pkg::*; #(
    parameter int MAX_EDGES = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         cmd,
    input  wire logic [$clog2(MAX_EDGES)-1:0] edge_index,
    input  wire logic signed [31:0]           sample_value,
    output plcdf_head_t                       head,
    output logic [$clog2(MAX_EDGES)-1:0]      head_index,
    output logic signed [31:0]                head_value,
    input  wire logic                         head_pop
);
    localparam int IDX_W = $clog2(MAX_EDGES);

    logic [1:0]              is_query_reg;
    logic [IDX_W-1:0]        index_reg [2];
    logic signed [31:0]      value_reg [2];
    logic                    rd_ptr_reg, rd_ptr_next;
    logic                    wr_ptr_reg, wr_ptr_next;
    logic [1:0]              fill_reg, fill_next;
    logic                    accept, keep;

    assign full   = (fill_reg == 2'd2);
    assign accept = push && !full;
    // Writes beyond the table are dropped here and never reach the back.
    assign keep   = (cmd == CMD_QUERY) || ({1'b0, edge_index} < (IDX_W+1)'(MAX_EDGES));

    assign head.valid    = (fill_reg != 2'd0);
    assign head.is_query = is_query_reg[rd_ptr_reg];
    assign head_index    = index_reg[rd_ptr_reg];
    assign head_value    = value_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (accept && keep)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (head_pop && head.valid)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        fill_next = fill_reg + 2'(accept && keep) - 2'(head_pop && head.valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            is_query_reg[wr_ptr_reg] <= (cmd == CMD_QUERY);
            index_reg[wr_ptr_reg]    <= edge_index;
            value_reg[wr_ptr_reg]    <= sample_value;
        end
    end
endmodule
`default_nettype wire

/* src/plcdf_back.sv */
`default_nettype none
module plcdf_back import plcdf_pkg::*; #(
    parameter int MAX_EDGES = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [$clog2(MAX_EDGES):0]     n_active,
    input  wire plcdf_head_t                    head,
    input  wire logic [$clog2(MAX_EDGES)-1:0]   head_index,
    input  wire logic signed [31:0]             head_value,
    output logic                                head_pop,
    output logic                                res_valid,
    output logic [FRAC_BITS:0]                  res_fraction,
    input  wire logic                           res_ready
);
    localparam int IDX_W = $clog2(MAX_EDGES);
    localparam int CNT_W = IDX_W + 1;
    localparam int NUM_W = CNT_W + 34;
    localparam int DEN_W = CNT_W + 32;
    localparam int REM_W = DEN_W + 1;
    localparam int K_W   = $clog2(FRAC_BITS);
    localparam logic [FRAC_BITS:0] ONE_FRAC = (FRAC_BITS+1)'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_E0, ST_EL, ST_SP, ST_SC, ST_RLO, ST_RUP,
        ST_MUL, ST_ADD, ST_CMP, ST_DIV, ST_RES
    } state_t;

    state_t                    state_reg, state_next;
    logic signed [31:0]        x_reg, x_next;
    logic signed [31:0]        e0_reg, e0_next;
    logic signed [31:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]          first_reg, first_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          step_reg, step_next;
    logic signed [32:0]        d_reg, d_next;
    logic signed [32:0]        diff_reg, diff_next;
    logic [DEN_W-1:0]          prod_reg, prod_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic signed [NUM_W-1:0]   num_reg, num_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [FRAC_BITS-1:0]      q_reg, q_next;
    logic [K_W-1:0]            k_reg, k_next;
    logic [FRAC_BITS:0]        frac_reg, frac_next;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_raddr;
    logic [31:0]               ram_rdata;
    logic signed [31:0]        rd;
    logic [CNT_W-1:0]          lo_idx;
    logic [REM_W-1:0]          rem_sh;

    plcdf_ram #(.WIDTH(32), .DEPTH(MAX_EDGES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_index),
        .wdata (head_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd           = $signed(ram_rdata);
    assign lo_idx       = first_reg - CNT_W'(1);
    assign rem_sh       = {rem_reg[REM_W-2:0], 1'b0};
    assign res_valid    = (state_reg == ST_RES);
    assign res_fraction = frac_reg;

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        e0_next    = e0_reg;
        lo_next    = lo_reg;
        first_next = first_reg;
        count_next = count_reg;
        step_next  = step_reg;
        d_next     = d_reg;
        diff_next  = diff_reg;
        prod_next  = prod_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        k_next     = k_reg;
        frac_next  = frac_reg;
        head_pop   = 1'b0;
        ram_we     = 1'b0;
        ram_raddr  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    head_pop = 1'b1;
                    if (head.is_query)
                    begin
                        x_next     = head_value;
                        state_next = ST_E0;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                    end
                end
            end
            ST_E0:
            begin
                e0_next    = rd;
                ram_raddr  = IDX_W'(n_active - CNT_W'(1));
                state_next = ST_EL;
            end
            ST_EL:
            begin
                first_next = '0;
                count_next = n_active;
                priority if (x_reg <= e0_reg)
                begin
                    frac_next  = '0;
                    state_next = ST_RES;
                end
                else if (x_reg >= rd)
                begin
                    frac_next  = ONE_FRAC;
                    state_next = ST_RES;
                end
                else
                begin
                    state_next = ST_SP;
                end
            end
            ST_SP:
            begin
                priority if (count_reg == '0)
                begin
                    if (first_reg == '0 || first_reg >= n_active)
                    begin
                        frac_next  = '0;
                        state_next = ST_RES;
                    end
                    else
                    begin
                        ram_raddr  = lo_idx[IDX_W-1:0];
                        state_next = ST_RLO;
                    end
                end
                else
                begin
                    step_next  = count_reg >> 1;
                    ram_raddr  = IDX_W'(first_reg + (count_reg >> 1));
                    state_next = ST_SC;
                end
            end
            ST_SC:
            begin
                if (rd < x_reg)
                begin
                    first_next = first_reg + step_reg + CNT_W'(1);
                    count_next = count_reg - step_reg - CNT_W'(1);
                end
                else
                begin
                    count_next = step_reg;
                end
                state_next = ST_SP;
            end
            ST_RLO:
            begin
                lo_next    = rd;
                ram_raddr  = IDX_W'(first_reg);
                state_next = ST_RUP;
            end
            ST_RUP:
            begin
                d_next     = 33'(rd) - 33'(lo_reg);
                diff_next  = 33'(x_reg) - 33'(lo_reg);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (d_reg <= 0)
                begin
                    frac_next  = '0;
                    state_next = ST_RES;
                end
                else
                begin
                    prod_next  = DEN_W'(lo_idx) * DEN_W'(d_reg[31:0]);
                    den_next   = DEN_W'(n_active - CNT_W'(1)) * DEN_W'(d_reg[31:0]);
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                num_next   = $signed({2'b00, prod_reg}) + NUM_W'(diff_reg);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                q_next   = '0;
                k_next   = '0;
                rem_next = REM_W'(num_reg[DEN_W-1:0]);
                priority if (num_reg <= 0)
                begin
                    frac_next  = '0;
                    state_next = ST_RES;
                end
                else if (num_reg >= $signed({2'b00, den_reg}))
                begin
                    frac_next  = ONE_FRAC;
                    state_next = ST_RES;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // One restoring step per cycle, quotient bit into the bottom.
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = rem_sh - {1'b0, den_reg};
                    q_next   = {q_reg[FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[FRAC_BITS-2:0], 1'b0};
                end
                k_next = k_reg + K_W'(1);
                if (k_reg == K_W'(FRAC_BITS - 1))
                begin
                    frac_next  = {1'b0, q_next};
                    state_next = ST_RES;
                end
            end
            ST_RES:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        e0_reg    <= e0_next;
        lo_reg    <= lo_next;
        first_reg <= first_next;
        count_reg <= count_next;
        step_reg  <= step_next;
        d_reg     <= d_next;
        diff_reg  <= diff_next;
        prod_reg  <= prod_next;
        den_reg   <= den_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        k_reg     <= k_next;
        frac_reg  <= frac_next;
    end
endmodule
`default_nettype wire
